FILE: hdl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared constants for the matrix chain cost evaluator: character codes,
// status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  // default sizes
  localparam int unsigned TableEntriesDef = 26;
  localparam int unsigned StackDepthDef   = 32;
  localparam int unsigned DimBitsDef      = 16;

  // fixed field widths
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SymW    = 8;
  localparam int unsigned CostW   = 56;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OpenW   = 6;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 64;

  // character codes
  localparam logic [SymW-1:0] LetterBase = 8'd65;
  localparam logic [SymW-1:0] OpenChar   = 8'd40;
  localparam logic [SymW-1:0] CloseChar  = 8'd41;

  localparam logic [OpenW-1:0] OpenMax = 6'd63;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  // request kinds
  localparam logic ReqDefine = 1'b0;
  localparam logic ReqChar   = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusMismatch  = 2'd1;
  localparam logic [StatusW-1:0] StatusMalformed = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/mcc_ram.sv
// ----------------------------------------------------------------------------
// mcc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/matrix_chain_cost_evaluator.sv
// ----------------------------------------------------------------------------
// matrix_chain_cost_evaluator
// Loads matrix dimensions into a table, then walks a parenthesized chain
// expression one character per transfer, summing the scalar multiplication
// cost on each ')' with one shared multiplier and a saturating accumulator.
// ----------------------------------------------------------------------------
//  channel  dir  signals                       contents
//  s_axis   in   tdata[47:0] tuser tlast       define item or expression char
//  m_axis   out  tdata[63:0]                   total cost and status
//
//  Per transfer: a define writes the table; a letter is read and pushed; ')'
//  reads two stack entries, then on a match makes two multiplier passes.
//  A last character holds its final cycle until the output register is free.
//  Reset clears the sequencer, stack pointer, counters and flags; the tables
//  need no clearing. s_axis_tready_o is low while a character is in work and
//  while a finished result waits for the output register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_cost_evaluator #(
  parameter int unsigned TABLE_ENTRIES = mcc_pkg::TableEntriesDef,
  parameter int unsigned STACK_DEPTH   = mcc_pkg::StackDepthDef,
  parameter int unsigned DIM_BITS      = mcc_pkg::DimBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // matrix_index[4:0], row_count[20:5], col_count[36:21], symbol[44:37]
  input  wire logic [mcc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type
  input  wire logic                         s_axis_tuser_i,
  input  wire logic                         s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // total_cost[55:0], status[57:56]
  output logic      [mcc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned EntryW = 2 * DIM_BITS;
  localparam int unsigned ProdW  = 3 * DIM_BITS;
  localparam int unsigned TabAW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned StkAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SpW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CostW  = mcc_pkg::CostW;
  localparam int unsigned SymW   = mcc_pkg::SymW;
  localparam int unsigned OpenW  = mcc_pkg::OpenW;
  localparam logic [SpW-1:0] SpFull = SpW'(STACK_DEPTH);
  localparam logic [SymW-1:0] TabCount = SymW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_POP2,
    S_POP1,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_PUSHBACK,
    S_FINISH
  } state_e;

  // input field split
  logic [mcc_pkg::IdxW-1:0]   in_idx;
  logic [mcc_pkg::CountW-1:0] in_rows;
  logic [mcc_pkg::CountW-1:0] in_cols;
  logic [SymW-1:0]            in_sym;
  assign in_idx  = s_axis_tdata_i[4:0];
  assign in_rows = s_axis_tdata_i[20:5];
  assign in_cols = s_axis_tdata_i[36:21];
  assign in_sym  = s_axis_tdata_i[44:37];

  // registers
  state_e                  state_q, state_d;
  logic [SymW-1:0]         sym_q, sym_d;
  logic                    last_q, last_d;
  logic [SpW-1:0]          sp_q, sp_d;
  logic [OpenW-1:0]        open_q, open_d;
  logic [CostW-1:0]        cost_q, cost_d;
  logic                    mism_q, mism_d;
  logic                    malf_q, malf_d;
  logic [EntryW-1:0]       p1_q, p1_d;
  logic [EntryW-1:0]       p2_q, p2_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic                    out_valid_q, out_valid_d;
  logic [CostW-1:0]        out_cost_q, out_cost_d;
  logic [mcc_pkg::StatusW-1:0] out_status_q, out_status_d;

  // memory ports
  logic              tab_we;
  logic [TabAW-1:0]  tab_waddr, tab_raddr;
  logic [EntryW-1:0] tab_wdata, tab_rdata;
  logic              stk_we;
  logic [StkAW-1:0]  stk_waddr, stk_raddr;
  logic [EntryW-1:0] stk_wdata, stk_rdata;

  // shared multiplier and accumulator
  logic [EntryW-1:0]   mul_a;
  logic [DIM_BITS-1:0] mul_b;
  logic [ProdW-1:0]    mul_p;
  logic [CostW:0]      acc_sum;

  logic            accept;
  logic            load_result;
  logic [SymW-1:0] letter_off;
  logic            is_letter;
  logic [SpW-1:0]  sp_m1, sp_m2;

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign letter_off = sym_q - mcc_pkg::LetterBase;
  assign is_letter  = (sym_q >= mcc_pkg::LetterBase) && (letter_off < TabCount);
  assign sp_m1      = sp_q - SpW'(1);
  assign sp_m2      = sp_q - SpW'(2);

  // dimension table written straight from a define transfer
  assign tab_we    = accept && (s_axis_tuser_i == mcc_pkg::ReqDefine) &&
                     (32'(in_idx) < TABLE_ENTRIES);
  assign tab_waddr = TabAW'(in_idx);
  assign tab_wdata = {DIM_BITS'(in_cols), DIM_BITS'(in_rows)};
  assign tab_raddr = TabAW'(letter_off);

  mcc_ram #(
    .Width(EntryW),
    .Depth(TABLE_ENTRIES)
  ) u_dim_table (
    .clk_i    (clk_i),
    .wr_en_i  (tab_we),
    .wr_addr_i(tab_waddr),
    .wr_data_i(tab_wdata),
    .rd_addr_i(tab_raddr),
    .rd_data_o(tab_rdata)
  );

  // operand stack: top read while decoding, the one below it next
  assign stk_raddr = (state_q == S_DECODE) ? sp_m1[StkAW-1:0] : sp_m2[StkAW-1:0];
  assign stk_waddr = sp_q[StkAW-1:0];
  assign stk_we    = (state_q == S_PUSH) ||
                     ((state_q == S_PUSHBACK) && (open_q != '0));
  assign stk_wdata = (state_q == S_PUSH) ? tab_rdata :
                     {p2_q[EntryW-1:DIM_BITS], p1_q[DIM_BITS-1:0]};

  mcc_ram #(
    .Width(EntryW),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (stk_we),
    .wr_addr_i(stk_waddr),
    .wr_data_i(stk_wdata),
    .rd_addr_i(stk_raddr),
    .rd_data_o(stk_rdata)
  );

  // rows*inner first, then times cols of the right operand
  assign mul_a   = (state_q == S_MUL1) ? {{DIM_BITS{1'b0}}, p1_q[DIM_BITS-1:0]}
                                       : prod_q[EntryW-1:0];
  assign mul_b   = (state_q == S_MUL1) ? p1_q[EntryW-1:DIM_BITS]
                                       : p2_q[EntryW-1:DIM_BITS];
  assign mul_p   = ProdW'(mul_a) * ProdW'(mul_b);
  assign acc_sum = {1'b0, cost_q} + (CostW + 1)'(prod_q);

  assign load_result = (state_q == S_FINISH) && last_q &&
                       (!out_valid_q || m_axis_tready_i);

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    last_d       = last_q;
    sp_d         = sp_q;
    open_d       = open_q;
    cost_d       = cost_q;
    mism_d       = mism_q;
    malf_d       = malf_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_cost_d   = out_cost_q;
    out_status_d = out_status_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (s_axis_tuser_i == mcc_pkg::ReqChar)) begin
          sym_d   = in_sym;
          last_d  = s_axis_tlast_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        if (!malf_q) begin
          if (sym_q == mcc_pkg::OpenChar) begin
            if (open_q == mcc_pkg::OpenMax) begin
              malf_d = 1'b1;
            end else begin
              open_d = open_q + OpenW'(1);
            end
          end else if (sym_q == mcc_pkg::CloseChar) begin
            if ((open_q == '0) || (sp_q < SpW'(2))) begin
              malf_d = 1'b1;
            end else begin
              state_d = S_POP2;
            end
          end else if (is_letter) begin
            if (sp_q == SpFull) begin
              malf_d = 1'b1;
            end else begin
              state_d = S_PUSH;
            end
          end else begin
            malf_d = 1'b1;
          end
        end
      end
      S_PUSH: begin
        sp_d    = sp_q + SpW'(1);
        state_d = S_FINISH;
      end
      S_POP2: begin
        p2_d    = stk_rdata;
        state_d = S_POP1;
      end
      S_POP1: begin
        p1_d   = stk_rdata;
        sp_d   = sp_m2;
        open_d = open_q - OpenW'(1);
        if (stk_rdata[EntryW-1:DIM_BITS] == p2_q[DIM_BITS-1:0]) begin
          state_d = S_MUL1;
        end else begin
          mism_d  = 1'b1;
          state_d = S_PUSHBACK;
        end
      end
      S_MUL1: begin
        prod_d  = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_p;
        state_d = S_ACC;
      end
      S_ACC: begin
        cost_d  = acc_sum[CostW] ? mcc_pkg::CostMax : acc_sum[CostW-1:0];
        state_d = S_PUSHBACK;
      end
      S_PUSHBACK: begin
        if (open_q != '0) begin
          sp_d = sp_q + SpW'(1);
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (load_result) begin
          out_valid_d = 1'b1;
          if (malf_q) begin
            out_cost_d   = '0;
            out_status_d = mcc_pkg::StatusMalformed;
          end else if (mism_q) begin
            out_cost_d   = '0;
            out_status_d = mcc_pkg::StatusMismatch;
          end else begin
            out_cost_d   = cost_q;
            out_status_d = mcc_pkg::StatusOk;
          end
          sp_d    = '0;
          open_d  = '0;
          cost_d  = '0;
          mism_d  = 1'b0;
          malf_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sym_q        <= '0;
      last_q       <= 1'b0;
      sp_q         <= '0;
      open_q       <= '0;
      cost_q       <= '0;
      mism_q       <= 1'b0;
      malf_q       <= 1'b0;
      p1_q         <= '0;
      p2_q         <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_cost_q   <= '0;
      out_status_q <= mcc_pkg::StatusOk;
    end else begin
      state_q      <= state_d;
      sym_q        <= sym_d;
      last_q       <= last_d;
      sp_q         <= sp_d;
      open_q       <= open_d;
      cost_q       <= cost_d;
      mism_q       <= mism_d;
      malf_q       <= malf_d;
      p1_q         <= p1_d;
      p2_q         <= p2_d;
      prod_q       <= prod_d;
      out_valid_q  <= out_valid_d;
      out_cost_q   <= out_cost_d;
      out_status_q <= out_status_d;
    end
  end

  // ports
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(mcc_pkg::OutDataW - CostW - mcc_pkg::StatusW){1'b0}},
                            out_status_q, out_cost_q};

`ifndef SYNTHESIS
  // stack pointer never passes the stack depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpFull)
    else $error("stack pointer beyond stack depth");

  // an error status always comes with a zero cost
  a_err_zero_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != mcc_pkg::StatusOk)) |-> (out_cost_q == '0))
    else $error("nonzero cost with error status");

  // malformed stays set until the expression result is loaded
  a_malf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (malf_q && !load_result) |=> malf_q)
    else $error("malformed flag dropped early");

  // a result only loads once the output register is free to take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !load_result)
    else $error("result loaded over a pending transfer");
`endif

endmodule

`default_nettype wire

FILE: sim/chain_cost_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chain_cost_checker
// Watches both stream channels of the matrix chain cost evaluator. Keeps its
// own dimension table and operand stack, predicts the cost result of every
// expression and compares each result transfer, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------

module chain_cost_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // matrix_index[4:0], row_count[20:5], col_count[36:21], symbol[44:37]
  input  logic [mcc_pkg::InDataW-1:0]     s_tdata_i,
  // req_type
  input  logic                            s_tuser_i,
  input  logic                            s_tlast_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // total_cost[55:0], status[57:56]
  input  logic [mcc_pkg::OutDataW-1:0]    m_tdata_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              ok_count_o,
  output int                              clash_count_o,
  output int                              malformed_count_o
);

  localparam int unsigned Entries    = mcc_pkg::TableEntriesDef;
  localparam int unsigned Depth      = mcc_pkg::StackDepthDef;
  localparam int unsigned CountW     = mcc_pkg::CountW;
  localparam int unsigned CostW      = mcc_pkg::CostW;
  localparam int unsigned StatusW    = mcc_pkg::StatusW;
  localparam int          DimMaskInt = (1 << mcc_pkg::DimBitsDef) - 1;
  localparam logic [CountW-1:0] DimMask = DimMaskInt[CountW-1:0];

  typedef struct packed {
    logic [CostW-1:0]   cost;
    logic [StatusW-1:0] status;
  } chain_result_t;

  // predicted machine state
  logic [CountW-1:0]        dim_rows   [Entries];
  logic [CountW-1:0]        dim_cols   [Entries];
  logic [CountW-1:0]        stack_rows [Depth];
  logic [CountW-1:0]        stack_cols [Depth];
  int unsigned              stack_top       = 0;
  logic [mcc_pkg::OpenW-1:0] open_groups    = '0;
  logic [CostW-1:0]         cost_sum        = '0;
  logic                     clash_seen      = 1'b0;
  logic                     malformed_seen  = 1'b0;

  chain_result_t            expected_costs[$];

  int failures   = 0;
  int pending    = 0;
  int ok_seen    = 0;
  int clash_seen_cnt = 0;
  int malformed_cnt  = 0;

  assign fail_count_o      = failures;
  assign pending_o         = pending;
  assign ok_count_o        = ok_seen;
  assign clash_count_o     = clash_seen_cnt;
  assign malformed_count_o = malformed_cnt;

  // ')' pops two operands, multiplies them out and maybe pushes the product
  task automatic close_group();
    logic [CountW-1:0] lrows, lcols, rrows, rcols;
    logic [63:0]       prod;
    if (open_groups == '0 || stack_top < 2) begin
      malformed_seen = 1'b1;
      return;
    end
    open_groups = open_groups - 1'b1;
    rrows = stack_rows[stack_top-1];
    rcols = stack_cols[stack_top-1];
    lrows = stack_rows[stack_top-2];
    lcols = stack_cols[stack_top-2];
    stack_top = stack_top - 2;
    if (lcols == rrows) begin
      prod = 64'(lrows) * 64'(lcols) * 64'(rcols);
      if (prod > 64'(mcc_pkg::CostMax) - 64'(cost_sum))
        cost_sum = mcc_pkg::CostMax;
      else
        cost_sum = cost_sum + prod[CostW-1:0];
    end else begin
      clash_seen = 1'b1;
    end
    if (open_groups != '0) begin
      stack_rows[stack_top] = lrows;
      stack_cols[stack_top] = rcols;
      stack_top++;
    end
  endtask

  // one expression character
  task automatic eval_symbol(input logic [mcc_pkg::SymW-1:0] sym);
    int letter;
    letter = int'(sym) - int'(mcc_pkg::LetterBase);
    if (sym == mcc_pkg::OpenChar) begin
      if (open_groups >= mcc_pkg::OpenMax)
        malformed_seen = 1'b1;
      else
        open_groups = open_groups + 1'b1;
    end else if (sym == mcc_pkg::CloseChar) begin
      close_group();
    end else if (letter >= 0 && letter < int'(Entries)) begin
      if (stack_top >= Depth) begin
        malformed_seen = 1'b1;
      end else begin
        stack_rows[stack_top] = dim_rows[letter];
        stack_cols[stack_top] = dim_cols[letter];
        stack_top++;
      end
    end else begin
      malformed_seen = 1'b1;
    end
  endtask

  // accepted input transfer
  task automatic take_item();
    logic [mcc_pkg::IdxW-1:0] idx;
    logic [CountW-1:0]        rows, cols;
    logic [mcc_pkg::SymW-1:0] sym;
    chain_result_t            res;
    idx  = s_tdata_i[mcc_pkg::IdxW-1:0];
    rows = s_tdata_i[mcc_pkg::IdxW +: CountW];
    cols = s_tdata_i[mcc_pkg::IdxW + CountW +: CountW];
    sym  = s_tdata_i[mcc_pkg::IdxW + 2*CountW +: mcc_pkg::SymW];
    if (s_tuser_i == mcc_pkg::ReqDefine) begin
      if (idx < Entries) begin
        dim_rows[idx] = rows & DimMask;
        dim_cols[idx] = cols & DimMask;
      end
    end else begin
      if (!malformed_seen)
        eval_symbol(sym);
      if (s_tlast_i) begin
        if (malformed_seen) begin
          res.cost   = '0;
          res.status = mcc_pkg::StatusMalformed;
          malformed_cnt++;
        end else if (clash_seen) begin
          res.cost   = '0;
          res.status = mcc_pkg::StatusMismatch;
          clash_seen_cnt++;
        end else begin
          res.cost   = cost_sum;
          res.status = mcc_pkg::StatusOk;
          ok_seen++;
        end
        expected_costs.push_back(res);
        stack_top      = 0;
        open_groups    = '0;
        cost_sum       = '0;
        clash_seen     = 1'b0;
        malformed_seen = 1'b0;
      end
    end
  endtask

  // accepted result transfer against the oldest prediction
  task automatic check_result();
    chain_result_t       want;
    logic [CostW-1:0]    got_cost;
    logic [StatusW-1:0]  got_status;
    got_cost   = m_tdata_i[CostW-1:0];
    got_status = m_tdata_i[CostW +: StatusW];
    if (expected_costs.size() == 0) begin
      $error("unexpected result: total_cost %0d status %0d", got_cost, got_status);
      failures++;
      return;
    end
    want = expected_costs.pop_front();
    if (got_cost !== want.cost) begin
      $error("total_cost: expected %0d, actual %0d", want.cost, got_cost);
      failures++;
    end
    if (got_status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got_status);
      failures++;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        take_item();
      if (m_tvalid_i && m_tready_i)
        check_result();
      pending = expected_costs.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the matrix chain cost evaluator. Loads the
// dimension table, runs directed expressions and one saturating chain, then
// random chains, broken and noisy expressions under changing idle mixes on
// both channels. Prediction and comparison live in chain_cost_checker.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ClkPeriod      = 10;
  localparam int ResetCycles    = 3;
  localparam int RandomItems    = 480;
  localparam int SaturationReps = 260;
  localparam int HoldCycles     = 400;
  localparam int SettleCycles   = 40;
  localparam int WatchdogLimit  = 4000;
  localparam int unsigned Entries = mcc_pkg::TableEntriesDef;
  localparam int MaxLeaves      = 8;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mcc_pkg::InDataW-1:0]    s_tdata  = '0;
  logic                           s_tuser  = 1'b0;
  logic                           s_tlast  = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mcc_pkg::OutDataW-1:0]   m_tdata;

  int fail_count, pending, ok_count, clash_count, malformed_count;

  int items_sent    = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit sink_hold_req = 1'b0;
  int quiet_cycles  = 0;

  logic [mcc_pkg::SymW-1:0] expr_chars[$];
  int                       chain_letter[MaxLeaves];

  always #(ClkPeriod / 2) clk = ~clk;

  matrix_chain_cost_evaluator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  chain_cost_checker cost_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .s_tvalid_i        (s_tvalid),
    .s_tready_i        (s_tready),
    .s_tdata_i         (s_tdata),
    .s_tuser_i         (s_tuser),
    .s_tlast_i         (s_tlast),
    .m_tvalid_i        (m_tvalid),
    .m_tready_i        (m_tready),
    .m_tdata_i         (m_tdata),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .ok_count_o        (ok_count),
    .clash_count_o     (clash_count),
    .malformed_count_o (malformed_count)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("matrix_chain_cost_evaluator: mismatch");
      $finish;
    end
  end

  // result sink: random stalls plus one long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req && hold_left == 0) begin
        hold_left     = HoldCycles;
        sink_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic logic [mcc_pkg::InDataW-1:0] pack_item(
    logic [mcc_pkg::IdxW-1:0]   idx,
    logic [mcc_pkg::CountW-1:0] rows,
    logic [mcc_pkg::CountW-1:0] cols,
    logic [mcc_pkg::SymW-1:0]   sym
  );
    return {{(mcc_pkg::InDataW - mcc_pkg::IdxW - 2*mcc_pkg::CountW - mcc_pkg::SymW){1'b0}},
            sym, cols, rows, idx};
  endfunction

  // one input transfer, with random gaps before it
  task automatic send_item(input logic kind, input logic [mcc_pkg::InDataW-1:0] data,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= kind;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // define item; unused symbol field and last flag carry junk
  task automatic send_define(input logic [mcc_pkg::IdxW-1:0] idx,
                             input logic [mcc_pkg::CountW-1:0] rows,
                             input logic [mcc_pkg::CountW-1:0] cols);
    items_sent++;
    send_item(mcc_pkg::ReqDefine, pack_item(idx, rows, cols, 8'($urandom)), 1'($urandom));
  endtask

  // expression character; unused fields carry junk
  task automatic send_char(input logic [mcc_pkg::SymW-1:0] sym, input logic last);
    items_sent++;
    send_item(mcc_pkg::ReqChar,
              pack_item(5'($urandom), 16'($urandom), 16'($urandom), sym), last);
  endtask

  task automatic send_expr();
    foreach (expr_chars[i])
      send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  task automatic send_text(input string text);
    int k;
    expr_chars.delete();
    for (k = 0; k < text.len(); k++)
      expr_chars.push_back(text[k]);
    send_expr();
  endtask

  // sender pause until every predicted result has arrived
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [mcc_pkg::SymW-1:0] letter_code(int pos);
    return 8'(int'(mcc_pkg::LetterBase) + pos);
  endfunction

  function automatic logic [mcc_pkg::SymW-1:0] random_letter();
    return letter_code($urandom_range(Entries - 1, 0));
  endfunction

  // mostly small dimensions, sometimes wide, zero or full scale
  function automatic logic [mcc_pkg::CountW-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80)
      return 16'($urandom_range(24, 1));
    else if (r < 92)
      return 16'($urandom);
    else if (r < 96)
      return 16'hFFFF;
    else
      return '0;
  endfunction

  // random full parenthesization over chain_letter[first +: leaves]
  function automatic void emit_tree(int leaves, int first);
    int split;
    if (leaves == 1) begin
      expr_chars.push_back(letter_code(chain_letter[first]));
      return;
    end
    split = $urandom_range(leaves - 1, 1);
    expr_chars.push_back(mcc_pkg::OpenChar);
    emit_tree(split, first);
    emit_tree(leaves - split, first + split);
    expr_chars.push_back(mcc_pkg::CloseChar);
  endfunction

  // define a chain with agreeing dimensions, bar one clash if asked; emit its tree
  task automatic build_chain(input int leaves, input bit want_clash);
    int                        order[Entries];
    logic [mcc_pkg::CountW-1:0] dims[MaxLeaves + 1];
    logic [mcc_pkg::CountW-1:0] cols;
    int                        bad, tmp, j, k;
    foreach (order[i])
      order[i] = i;
    for (k = Entries - 1; k > 0; k--) begin
      j        = $urandom_range(k, 0);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (dims[i])
      dims[i] = pick_dim();
    bad = -1;
    if (want_clash && leaves > 1)
      bad = $urandom_range(leaves - 2, 0);
    for (k = 0; k < leaves; k++) begin
      chain_letter[k] = order[k];
      // stray define outside the table now and then
      if ($urandom_range(19) == 0)
        send_define(5'($urandom_range(31, Entries)), 16'($urandom), 16'($urandom));
      cols = dims[k+1];
      if (k == bad)
        cols = cols ^ 16'($urandom_range(15, 1));
      send_define(5'(order[k]), dims[k], cols);
    end
    emit_tree(leaves, 0);
  endtask

  // one random expression of a randomly chosen shape
  task automatic random_expression();
    int unsigned pick, r;
    int          n, p;
    expr_chars.delete();
    pick = $urandom_range(99);
    if (pick < 62) begin
      build_chain($urandom_range(MaxLeaves, 1), $urandom_range(7) == 0);
    end else if (pick < 72) begin
      // open groups or operands left at the end
      build_chain($urandom_range(6, 2), 1'b0);
      repeat ($urandom_range(3, 1))
        if (expr_chars.size() > 1)
          void'(expr_chars.pop_back());
    end else if (pick < 84) begin
      // noise
      n = $urandom_range(12, 1);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 40)
          expr_chars.push_back(random_letter());
        else if (r < 60)
          expr_chars.push_back(mcc_pkg::OpenChar);
        else if (r < 80)
          expr_chars.push_back(mcc_pkg::CloseChar);
        else
          expr_chars.push_back(8'($urandom));
      end
    end else if (pick < 94) begin
      // well-formed chain with one character broken
      build_chain($urandom_range(6, 2), 1'b0);
      p = $urandom_range(expr_chars.size() - 1, 0);
      case ($urandom_range(3))
        0: expr_chars[p] = 8'($urandom);
        1: expr_chars.delete(p);
        2: expr_chars.insert(p, mcc_pkg::CloseChar);
        default: expr_chars.insert(p, mcc_pkg::OpenChar);
      endcase
      if (expr_chars.size() == 0)
        expr_chars.push_back(random_letter());
    end else if ($urandom_range(1) == 0) begin
      // operand stack around its depth
      expr_chars.push_back(mcc_pkg::OpenChar);
      repeat ($urandom_range(mcc_pkg::StackDepthDef + 2, mcc_pkg::StackDepthDef - 1))
        expr_chars.push_back(random_letter());
      expr_chars.push_back(mcc_pkg::CloseChar);
    end else begin
      // open count around its limit
      repeat ($urandom_range(66, 62))
        expr_chars.push_back(mcc_pkg::OpenChar);
      expr_chars.push_back(random_letter());
      expr_chars.push_back(random_letter());
      expr_chars.push_back(mcc_pkg::CloseChar);
    end
    send_expr();
  endtask

  initial begin : stimulus
    int k, ph, base;
    src_idle_pct  = 32;
    sink_idle_pct = 83;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // table load: consecutive letters chain up
    for (k = 0; k < Entries; k++)
      send_define(5'(k), 16'(k + 2), 16'(k + 3));

    // directed: ignored defines, full-scale operands, each error kind
    send_define(5'd31, 16'hFFFF, 16'h0000);
    send_define(5'(Entries), 16'h0000, 16'hFFFF);
    send_define(5'(Entries - 2), 16'hFFFF, 16'hFFFF);
    send_define(5'(Entries - 1), 16'hFFFF, 16'hFFFF);
    send_text("(YZ)");
    send_text("(AB)");
    send_text("(AC)");
    send_text("(AC))");
    send_text(")");
    send_text("(A)");
    send_text("a");
    expr_chars.delete();
    expr_chars.push_back(8'h00);
    expr_chars.push_back(8'hFF);
    send_expr();
    send_text("A");
    send_text("((AB");
    wait_results_drained();

    // cost saturation: full-scale squares multiplied again and again
    expr_chars.delete();
    expr_chars.push_back(mcc_pkg::OpenChar);
    expr_chars.push_back(letter_code(Entries - 2));
    repeat (SaturationReps) begin
      expr_chars.push_back(mcc_pkg::OpenChar);
      expr_chars.push_back(letter_code(Entries - 2));
      expr_chars.push_back(mcc_pkg::CloseChar);
    end
    send_expr();
    wait_results_drained();

    // random expressions under three idle mixes
    base = items_sent;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 32;
          sink_idle_pct = 83;
        end
        1: begin
          src_idle_pct  = 83;
          sink_idle_pct = 32;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          sink_hold_req = 1'b1;
        end
      endcase
      while (items_sent - base < (ph + 1) * RandomItems / 3)
        random_expression();
      wait_results_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("run covered %0d items (%0d random) incl. error cases and cost saturation",
             items_sent, items_sent - base);
    $display("results: %0d ok, %0d dimension clash, %0d malformed; %0d check failures",
             ok_count, clash_count, malformed_count, fail_count);
    if (fail_count == 0)
      $display("matrix_chain_cost_evaluator: match");
    else
      $display("matrix_chain_cost_evaluator: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mcc_pkg.sv
hdl/mcc_ram.sv
hdl/matrix_chain_cost_evaluator.sv
sim/chain_cost_checker.sv
sim/testbench.sv
